// ===== hw/rtl/v3au_pkg.sv =====
// ----------------------------------------------------------------------------
// v3au_pkg
// Shared types and constants of the 3D vector arithmetic unit.
// ----------------------------------------------------------------------------
package v3au_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned ActW = 4;

  typedef enum logic [ActW-1:0] {
    ACT_ADD   = 4'd0,
    ACT_ADDS  = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_SUBS  = 4'd3,
    ACT_MUL   = 4'd4,
    ACT_MULS  = 4'd5,
    ACT_DIV   = 4'd6,
    ACT_DIVS  = 4'd7,
    ACT_DOT   = 4'd8,
    ACT_CROSS = 4'd9,
    ACT_LEN   = 4'd10,
    ACT_NORM  = 4'd11
  } action_t;

  typedef struct packed {
    logic [ActW-1:0]         action;
    logic signed [WordW-1:0] a_x;
    logic signed [WordW-1:0] a_y;
    logic signed [WordW-1:0] a_z;
    logic signed [WordW-1:0] a_w;
    logic signed [WordW-1:0] b_x;
    logic signed [WordW-1:0] b_y;
    logic signed [WordW-1:0] b_z;
    logic signed [WordW-1:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] r_x;
    logic signed [WordW-1:0] r_y;
    logic signed [WordW-1:0] r_z;
    logic signed [WordW-1:0] r_w;
    logic signed [WordW-1:0] scalar_out;
    logic                    fault;
  } out_item_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [WordW-1:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sh7FFFFFFF;
    lo = -72'sh80000000;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[WordW-1:0];
  endfunction

endpackage

// ===== hw/rtl/v3au_lane.sv =====
// ----------------------------------------------------------------------------
// v3au_lane
// One component lane: operand selection, product and quotient, fully
// pipelined with a bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
module v3au_lane #(
  parameter int unsigned FRAC_BITS = v3au_pkg::FracBitsDefault,
  parameter int unsigned LAT = 70
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [v3au_pkg::ActW-1:0] action,
  input  logic signed [31:0]       a,
  input  logic signed [31:0]       b,
  input  logic signed [31:0]       s,
  input  logic signed [31:0]       c1,
  input  logic signed [31:0]       c2,
  input  logic signed [31:0]       c3,
  input  logic signed [31:0]       c4,
  input  logic [32:0]              len,
  input  logic                     len_ok,
  output logic signed [31:0]       r,
  output logic signed [65:0]       prod,
  output logic                     fault
);
  // quotient: dividend magnitude << FRAC_BITS fits 32+FRAC_BITS bits, divisor up to 33
  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned DW = 34;

  // stage 1: registered operands and products
  logic [v3au_pkg::ActW-1:0] act1;
  logic signed [32:0] sum1;
  logic signed [63:0] mp1, cp1, cp2;
  logic signed [31:0] dvd1;
  logic signed [33:0] dvs1;
  logic               div1;

  logic signed [31:0] opb;
  always_comb begin
    opb = b;
    if (action == v3au_pkg::ACT_ADDS || action == v3au_pkg::ACT_SUBS ||
        action == v3au_pkg::ACT_MULS || action == v3au_pkg::ACT_DIVS) begin
      opb = s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= action;
      if (action == v3au_pkg::ACT_SUB || action == v3au_pkg::ACT_SUBS) begin
        sum1 <= 33'(a) - 33'(opb);
      end else begin
        sum1 <= 33'(a) + 33'(opb);
      end
      mp1  <= a * opb;
      cp1  <= c1 * c2;
      cp2  <= c3 * c4;
      dvd1 <= a;
      if (action == v3au_pkg::ACT_NORM) begin
        dvs1 <= {1'b0, len};
      end else begin
        dvs1 <= 34'(opb);
      end
      div1 <= (action == v3au_pkg::ACT_DIV || action == v3au_pkg::ACT_DIVS ||
               (action == v3au_pkg::ACT_NORM && len_ok));
    end
  end

  // stage 2: direct result candidates and divider setup
  logic signed [31:0] dres2;
  logic signed [65:0] prod2;
  logic               zf2, sg2, dv2;
  logic [NW-1:0]      nm2;
  logic [DW-1:0]      dm2;
  logic signed [31:0] zq2;
  logic [v3au_pkg::ActW-1:0] act2;

  logic signed [65:0] cdiff;
  always_comb begin
    cdiff = 66'(cp1) - 66'(cp2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act1;
      dv2  <= div1;
      prod2 <= 66'(mp1);
      case (act1)
        v3au_pkg::ACT_ADD, v3au_pkg::ACT_ADDS, v3au_pkg::ACT_SUB, v3au_pkg::ACT_SUBS:
          dres2 <= v3au_pkg::sat32(72'(sum1));
        v3au_pkg::ACT_MUL, v3au_pkg::ACT_MULS:
          dres2 <= v3au_pkg::sat32(72'(mp1 >>> FRAC_BITS));
        v3au_pkg::ACT_CROSS:
          dres2 <= v3au_pkg::sat32(72'(cdiff >>> FRAC_BITS));
        default: dres2 <= '0;
      endcase
      zf2 <= (dvs1 == '0);
      sg2 <= dvd1[31] ^ dvs1[33];
      nm2 <= NW'(dvd1[31] ? -33'(dvd1) : 33'(dvd1)) << FRAC_BITS;
      dm2 <= dvs1[33] ? DW'(-dvs1) : DW'(dvs1);
      zq2 <= (dvd1 > 0) ? 32'sh7FFFFFFF : ((dvd1 < 0) ? 32'sh80000000 : 32'sd0);
    end
  end

  // restoring divider, one quotient bit per stage
  logic [NW-1:0] rq  [0:NW];
  logic [DW:0]   rem [0:NW];
  logic [DW-1:0] dd  [0:NW];
  logic          pzf [0:NW];
  logic          psg [0:NW];
  logic          pdv [0:NW];
  logic signed [31:0] pzq [0:NW];
  logic signed [31:0] pdr [0:NW];
  logic [v3au_pkg::ActW-1:0] pac [0:NW];

  always_comb begin
    rq[0]  = nm2;
    rem[0] = '0;
    dd[0]  = dm2;
    pzf[0] = zf2;
    psg[0] = sg2;
    pdv[0] = dv2;
    pzq[0] = zq2;
    pdr[0] = dres2;
    pac[0] = act2;
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW:0] tr;
    logic        ge;
    always_comb begin
      tr = {rem[k][DW-1:0], rq[k][NW-1]};
      ge = (tr >= {1'b0, dd[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? (tr - {1'b0, dd[k]}) : tr;
        rq[k+1]  <= {rq[k][NW-2:0], ge};
        dd[k+1]  <= dd[k];
        pzf[k+1] <= pzf[k];
        psg[k+1] <= psg[k];
        pdv[k+1] <= pdv[k];
        pzq[k+1] <= pzq[k];
        pdr[k+1] <= pdr[k];
        pac[k+1] <= pac[k];
      end
    end
  end

  // final stage: sign, saturation and selection
  logic [NW-1:0] q;
  always_comb begin
    q = rq[NW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pac[NW] == v3au_pkg::ACT_DIV || pac[NW] == v3au_pkg::ACT_DIVS ||
          pac[NW] == v3au_pkg::ACT_NORM) begin
        if (!pdv[NW]) begin
          r     <= (pac[NW] == v3au_pkg::ACT_NORM) ? 32'sd0 : pzq[NW];
          fault <= 1'b1;
        end else if (pzf[NW]) begin
          r     <= pzq[NW];
          fault <= 1'b1;
        end else if (psg[NW]) begin
          r     <= (q > NW'(33'h080000000)) ? 32'sh80000000 : -q[31:0];
          fault <= 1'b0;
        end else begin
          r     <= (q > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : q[31:0];
          fault <= 1'b0;
        end
      end else begin
        r     <= pdr[NW];
        fault <= 1'b0;
      end
    end
  end

  // product kept raw for the dot merge, delayed to match
  logic signed [65:0] pd [0:LAT-3];
  always_ff @(posedge clk) begin
    if (en) pd[0] <= prod2;
  end
  for (genvar k = 1; k <= LAT - 3; k++) begin : g_pd
    always_ff @(posedge clk) begin
      if (en) pd[k] <= pd[k-1];
    end
  end
  assign prod = pd[LAT-3];

endmodule

// ===== hw/rtl/v3au_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3au_sqrt
// Pipelined squared length and floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v3au_sqrt (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  output logic [32:0]        root
);
  logic [63:0] sx, sy, sz;
  logic [31:0] mx, my, mz;
  always_comb begin
    mx = x[31] ? 32'(-x) : 32'(x);
    my = y[31] ? 32'(-y) : 32'(y);
    mz = z[31] ? 32'(-z) : 32'(z);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx <= mx * mx;
      sy <= my * my;
      sz <= mz * mz;
    end
  end

  logic [65:0] n  [0:33];
  logic [67:0] rm [0:33];
  logic [32:0] rt [0:33];

  always_ff @(posedge clk) begin
    if (en) begin
      n[0]  <= 66'(sx) + 66'(sy) + 66'(sz);
      rm[0] <= '0;
      rt[0] <= '0;
    end
  end

  for (genvar k = 0; k < 33; k++) begin : g_sq
    logic [67:0] tr, tt;
    logic        ge;
    always_comb begin
      tr = {rm[k][65:0], n[k][65:64]};
      tt = {33'd0, rt[k], 2'b01};
      ge = (tr >= tt);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= ge ? (tr - tt) : tr;
        rt[k+1] <= {rt[k][31:0], ge};
        n[k+1]  <= {n[k][63:0], 2'b00};
      end
    end
  end
  assign root = rt[33];
endmodule

// ===== hw/rtl/vector3_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Three-lane Q16.16 vector ALU: add, sub, mul, div, dot, cross, length and
// normalize, with saturation and a division-by-zero fault flag.
//
// Usage: present a transaction on in_valid/in_data; it is taken when in_stall
// is low. Results leave on out_valid/out_data, held while out_stall is high.
// Every transaction passes through one fixed pipeline: 35 stages of squared
// length and square root, then FRAC_BITS+35 stages of the lanes, whose length
// is set by the one-bit-per-stage restoring divider, plus an output register.
// Throughput is one transaction per cycle while out_stall is low. The pipeline
// advances whenever the output register is empty or being taken; a stall from
// the receiver while a result is held freezes the whole pipeline and raises
// in_stall. Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = v3au_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  v3au_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output v3au_pkg::out_item_t  out_data
);
  localparam int unsigned SQ_LAT = 35;
  localparam int unsigned LANE_LAT = 32 + FRAC_BITS + 3;
  localparam int unsigned TOT = SQ_LAT + LANE_LAT;

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [TOT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  // input delay line aligned with the square root
  v3au_pkg::in_item_t dq [0:SQ_LAT-1];
  always_ff @(posedge clk) begin
    if (en) dq[0] <= in_data;
  end
  for (genvar k = 1; k < SQ_LAT; k++) begin : g_dq
    always_ff @(posedge clk) begin
      if (en) dq[k] <= dq[k-1];
    end
  end

  logic [32:0] root;
  v3au_sqrt u_sqrt (
    .clk(clk), .en(en), .x(in_data.a_x), .y(in_data.a_y), .z(in_data.a_z), .root(root)
  );

  v3au_pkg::in_item_t d;
  assign d = dq[SQ_LAT-1];

  logic signed [31:0] rx, ry, rz;
  logic signed [65:0] px, py, pz;
  logic fx, fy, fz;
  logic len_ok;
  assign len_ok = (root != '0);

  v3au_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LANE_LAT)) u_lx (
    .clk(clk), .en(en), .action(d.action), .a(d.a_x), .b(d.b_x), .s(d.scalar_in),
    .c1(d.a_y), .c2(d.b_z), .c3(d.a_z), .c4(d.b_y), .len(root), .len_ok(len_ok),
    .r(rx), .prod(px), .fault(fx)
  );
  v3au_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LANE_LAT)) u_ly (
    .clk(clk), .en(en), .action(d.action), .a(d.a_y), .b(d.b_y), .s(d.scalar_in),
    .c1(d.a_z), .c2(d.b_x), .c3(d.a_x), .c4(d.b_z), .len(root), .len_ok(len_ok),
    .r(ry), .prod(py), .fault(fy)
  );
  v3au_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LANE_LAT)) u_lz (
    .clk(clk), .en(en), .action(d.action), .a(d.a_z), .b(d.b_z), .s(d.scalar_in),
    .c1(d.a_x), .c2(d.b_y), .c3(d.a_y), .c4(d.b_x), .len(root), .len_ok(len_ok),
    .r(rz), .prod(pz), .fault(fz)
  );

  // side delay line of action, w and length to the merge
  logic [v3au_pkg::ActW-1:0] sa [0:LANE_LAT-1];
  logic signed [31:0]        sw [0:LANE_LAT-1];
  logic [32:0]               sl [0:LANE_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= d.action;
      sw[0] <= d.a_w;
      sl[0] <= root;
    end
  end
  for (genvar k = 1; k < LANE_LAT; k++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        sa[k] <= sa[k-1];
        sw[k] <= sw[k-1];
        sl[k] <= sl[k-1];
      end
    end
  end

  // merge stage
  logic [v3au_pkg::ActW-1:0] ma;
  logic signed [67:0] dsum;
  logic [32:0] ml;
  assign ma = sa[LANE_LAT-1];
  assign ml = sl[LANE_LAT-1];
  assign dsum = 68'(px) + 68'(py) + 68'(pz);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.r_w <= sw[LANE_LAT-1];
      case (ma)
        v3au_pkg::ACT_DOT: begin
          out_data.r_x        <= '0;
          out_data.r_y        <= '0;
          out_data.r_z        <= '0;
          out_data.scalar_out <= v3au_pkg::sat32(72'(dsum >>> FRAC_BITS));
          out_data.fault      <= 1'b0;
        end
        v3au_pkg::ACT_LEN: begin
          out_data.r_x        <= '0;
          out_data.r_y        <= '0;
          out_data.r_z        <= '0;
          out_data.scalar_out <= (ml > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(ml[31:0]);
          out_data.fault      <= 1'b0;
        end
        default: begin
          if (ma <= v3au_pkg::ACT_NORM) begin
            out_data.r_x   <= rx;
            out_data.r_y   <= ry;
            out_data.r_z   <= rz;
            out_data.fault <= fx | fy | fz;
          end else begin
            out_data.r_x   <= '0;
            out_data.r_y   <= '0;
            out_data.r_z   <= '0;
            out_data.fault <= 1'b0;
          end
          out_data.scalar_out <= '0;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) in_stall == (out_valid && out_stall))
    else $error("stall mismatch");
  assert property (@(posedge clk) disable iff (rst)
      out_valid && out_data.fault |-> out_data.scalar_out == '0)
    else $error("fault with scalar result");
endmodule

// ===== sim/vector3_arithmetic_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_tb
// Self-checking testbench of the 3D vector arithmetic unit. Each accepted
// transaction is run through a fixed-point predictor of every operation, and
// the expected results are queued and compared field by field with the
// outputs, under random idling on both channels and long receiver stalls.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = 16;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 120;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  v3au_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  v3au_pkg::out_item_t out_data;

  v3au_pkg::out_item_t vec_results_q[$];
  int mismatches;
  int cycles;
  int idle_pct;
  bit hold_off;
  bit full_rate;

  vector3_arithmetic_unit #(.FRAC_BITS(Frac)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
    return v >>> Frac;
  endfunction

  function automatic logic signed [31:0] fx_quot(input logic signed [127:0] a,
                                                input logic signed [127:0] d,
                                                inout logic flt);
    logic signed [127:0] q;
    if (d == 0) begin
      flt = 1'b1;
      if (a > 0) return 32'sh7FFFFFFF;
      if (a < 0) return 32'sh80000000;
      return 32'sd0;
    end
    q = (a <<< Frac) / d;
    return clamp32(q);
  endfunction

  function automatic logic [127:0] floor_root(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic v3au_pkg::out_item_t predict_vec(input v3au_pkg::in_item_t t);
    v3au_pkg::out_item_t r;
    logic signed [127:0] ax, ay, az, bx, by, bz, s, len;
    logic flt;
    ax = t.a_x; ay = t.a_y; az = t.a_z;
    bx = t.b_x; by = t.b_y; bz = t.b_z;
    s = t.scalar_in;
    flt = 1'b0;
    r = '0;
    r.r_w = t.a_w;
    case (t.action)
      v3au_pkg::ACT_ADD: begin
        r.r_x = clamp32(ax + bx); r.r_y = clamp32(ay + by); r.r_z = clamp32(az + bz);
      end
      v3au_pkg::ACT_ADDS: begin
        r.r_x = clamp32(ax + s); r.r_y = clamp32(ay + s); r.r_z = clamp32(az + s);
      end
      v3au_pkg::ACT_SUB: begin
        r.r_x = clamp32(ax - bx); r.r_y = clamp32(ay - by); r.r_z = clamp32(az - bz);
      end
      v3au_pkg::ACT_SUBS: begin
        r.r_x = clamp32(ax - s); r.r_y = clamp32(ay - s); r.r_z = clamp32(az - s);
      end
      v3au_pkg::ACT_MUL: begin
        r.r_x = clamp32(floor_frac(ax * bx));
        r.r_y = clamp32(floor_frac(ay * by));
        r.r_z = clamp32(floor_frac(az * bz));
      end
      v3au_pkg::ACT_MULS: begin
        r.r_x = clamp32(floor_frac(ax * s));
        r.r_y = clamp32(floor_frac(ay * s));
        r.r_z = clamp32(floor_frac(az * s));
      end
      v3au_pkg::ACT_DIV: begin
        r.r_x = fx_quot(ax, bx, flt);
        r.r_y = fx_quot(ay, by, flt);
        r.r_z = fx_quot(az, bz, flt);
      end
      v3au_pkg::ACT_DIVS: begin
        r.r_x = fx_quot(ax, s, flt);
        r.r_y = fx_quot(ay, s, flt);
        r.r_z = fx_quot(az, s, flt);
      end
      v3au_pkg::ACT_DOT: r.scalar_out = clamp32(floor_frac(ax * bx + ay * by + az * bz));
      v3au_pkg::ACT_CROSS: begin
        r.r_x = clamp32(floor_frac(ay * bz - az * by));
        r.r_y = clamp32(floor_frac(az * bx - ax * bz));
        r.r_z = clamp32(floor_frac(ax * by - ay * bx));
      end
      v3au_pkg::ACT_LEN, v3au_pkg::ACT_NORM: begin
        len = floor_root(ax * ax + ay * ay + az * az);
        if (t.action == v3au_pkg::ACT_LEN) begin
          r.scalar_out = clamp32(len);
        end else begin
          r.r_x = fx_quot(ax, len, flt);
          r.r_y = fx_quot(ay, len, flt);
          r.r_z = fx_quot(az, len, flt);
        end
      end
      default: ;
    endcase
    r.fault = flt;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
      4, 5: return $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vec(input v3au_pkg::in_item_t t);
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vec_results_q.push_back(predict_vec(t));
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_rand(input logic [3:0] act);
    v3au_pkg::in_item_t t;
    t.action = act;
    t.a_x = rand_word(); t.a_y = rand_word(); t.a_z = rand_word();
    t.a_w = $urandom;
    t.b_x = rand_word(); t.b_y = rand_word(); t.b_z = rand_word();
    t.scalar_in = rand_word();
    if ($urandom_range(0, 7) == 0) t.scalar_in = '0;
    if ($urandom_range(0, 7) == 0) t.b_y = '0;
    send_vec(t);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (vec_results_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    v3au_pkg::in_item_t t;
    for (int a = 0; a < 16; a++) begin
      t.action = 4'(a);
      t.a_x = 32'h7FFFFFFF; t.a_y = 32'h80000000; t.a_z = 32'h00018000;
      t.a_w = 32'hFFFFFFFF;
      t.b_x = 32'h7FFFFFFF; t.b_y = 32'h00000000; t.b_z = 32'hFFFF8000;
      t.scalar_in = (a == v3au_pkg::ACT_DIVS) ? 32'd0 : 32'h80000000;
      send_vec(t);
    end
    t = '0;
    t.action = v3au_pkg::ACT_NORM;
    send_vec(t);
    t.action = v3au_pkg::ACT_DIV;
    t.a_x = 32'h00010000; t.a_y = 32'hFFFF0000;
    send_vec(t);
    t.action = v3au_pkg::ACT_LEN;
    t.a_x = 32'h80000000; t.a_y = 32'h80000000; t.a_z = 32'h80000000;
    send_vec(t);
    t.action = v3au_pkg::ACT_NORM;
    send_vec(t);
    t.action = v3au_pkg::ACT_DOT;
    t.b_x = 32'h80000000; t.b_y = 32'h80000000; t.b_z = 32'h80000000;
    send_vec(t);
    t.action = v3au_pkg::ACT_MUL;
    t.a_x = 32'hFFFFFFFF; t.b_x = 32'h00000001;
    send_vec(t);
    drain_results();
  endtask

  task automatic test_random_idle();
    idle_pct = 21;
    repeat (300) send_rand(4'($urandom_range(0, 15)));
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    full_rate = 1'b1;
    repeat (200) send_rand(4'($urandom_range(0, 11)));
    drain_results();
    full_rate = 1'b0;
  endtask

  task automatic test_backpressure();
    idle_pct = 21;
    hold_off = 1'b1;
    repeat (230) send_rand(4'($urandom_range(0, 15)));
    drain_results();
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (vec_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_data);
      end else begin
        v3au_pkg::out_item_t e;
        e = vec_results_q.pop_front();
        if (e.r_x !== out_data.r_x || e.r_y !== out_data.r_y ||
            e.r_z !== out_data.r_z || e.r_w !== out_data.r_w ||
            e.scalar_out !== out_data.scalar_out || e.fault !== out_data.fault) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_data);
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    while (!hold_off) begin
      out_stall <= !full_rate && ($urandom_range(0, 99) < 21);
      @(negedge clk);
    end
    out_stall <= 1'b1;
    repeat (300) @(negedge clk);
    forever begin
      out_stall <= !full_rate && ($urandom_range(0, 99) < 21);
      @(negedge clk);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    idle_pct = 21;
    hold_off = 1'b0;
    full_rate = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_idle();
    test_back_to_back();
    test_backpressure();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && vec_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
